[rtl/bgd_pkg.sv]
package bgd_pkg;

  // button count, index width and field widths
  localparam int unsigned NumButtons = 4;
  localparam int unsigned IdxW       = 2;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned ThreshW    = 16;
  localparam int unsigned TapW       = 2;

  // tap count ceiling
  localparam logic [TapW-1:0] TapMax = TapW'(2);

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] RegLongPress = 2'd0;
  localparam logic [1:0] RegDoubleTap = 2'd1;
  localparam logic [1:0] RegEnableMsk = 2'd2;

  // reset values of the configuration registers
  localparam logic [ThreshW-1:0]    LongPressRst = ThreshW'(1000);
  localparam logic [ThreshW-1:0]    DoubleTapRst = ThreshW'(400);
  localparam logic [NumButtons-1:0] EnableMskRst = NumButtons'(1);

  // per-button state word held in the state memory
  typedef struct packed {
    logic             pressed;
    logic [TimeW-1:0] hold_t0;
    logic [TimeW-1:0] tap_t0;
    logic [TapW-1:0]  taps;
    logic             long_done;
  } btn_ctx_t;

  localparam int unsigned StateW = $bits(btn_ctx_t);

  // event flags of one result word
  typedef struct packed {
    logic long_end;
    logic long_start;
    logic double_tap;
    logic single_tap;
  } evt_flags_t;

endpackage

[rtl/bgd_ram.sv]
module bgd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/button_gesture_detector_core.sv]
// channel   dir  tdata (low bit up)                    tuser
// s_axis    in   button_held, now_ms[31:0], 7'b0       button_index
// m_axis    out  single_tap, double_tap, long_start,   event_button
//                long_end, 4'b0
// apb       in   0: long_press_ms, 4: double_tap_ms, 8: button_enable_mask
//
// one word per cycle sustained while m_axis accepts; a word is registered in the
// update stage, where the state memory data arrives and the update is computed,
// then in the output register, which drives m_axis tvalid
// back-to-back words for the same button are served by forwarding the update
// reset clears the entry valid bits, so every button starts from zero state
// a stalled m_axis holds the update stage and, behind it, s_axis tready
module button_gesture_detector_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // poll samples
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // button_held, now_ms, zero fill
  input  logic [1:0]  s_axis_tuser,   // button_index
  // gesture events
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // single_tap, double_tap, long_start, long_end, zero fill
  output logic [1:0]  m_axis_tuser,   // event_button
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bgd_pkg::*;

  localparam int unsigned RamAw = (NumButtons > 1) ? $clog2(NumButtons) : 1;

  // configuration registers
  logic [ThreshW-1:0]    long_ms_q;
  logic [ThreshW-1:0]    dtap_ms_q;
  logic [NumButtons-1:0] en_mask_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ms_q <= LongPressRst;
      dtap_ms_q <= DoubleTapRst;
      en_mask_q <= EnableMskRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegLongPress: long_ms_q <= pwdata[ThreshW-1:0];
        RegDoubleTap: dtap_ms_q <= pwdata[ThreshW-1:0];
        RegEnableMsk: en_mask_q <= pwdata[NumButtons-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegLongPress: prdata = 32'(long_ms_q);
      RegDoubleTap: prdata = 32'(dtap_ms_q);
      RegEnableMsk: prdata = 32'(en_mask_q);
      default:      prdata = '0;
    endcase
  end

  // handshake and stage control
  logic                  in_acc;
  logic                  s1_adv;
  logic                  s1_vld_q;
  logic [IdxW-1:0]       s1_idx_q;
  logic                  s1_held_q;
  logic [TimeW-1:0]      s1_now_q;
  logic                  rd_vld_q;
  logic                  fwd_q;
  btn_ctx_t              fwd_st_q;
  logic [NumButtons-1:0] ent_vld_q;
  logic                  out_vld_q;
  evt_flags_t            out_flags_q;
  logic [IdxW-1:0]       out_btn_q;

  logic [StateW-1:0]     ram_rdata;
  logic                  in_range;
  logic                  btn_en;
  logic                  st_wr;
  btn_ctx_t              cur_st;
  btn_ctx_t              nxt_st;
  evt_flags_t            flags;
  logic [TimeW-1:0]      hold_el;
  logic [TimeW-1:0]      tap_el;
  logic                  hold_long;
  logic                  release_ev;

  assign s1_adv        = s1_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~s1_vld_q | s1_adv;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  assign in_range = 32'(s1_idx_q) < NumButtons;
  assign btn_en   = in_range & en_mask_q[s1_idx_q[RamAw-1:0]];
  assign st_wr    = s1_adv & btn_en;

  // state memory, one entry per button
  bgd_ram #(
    .Width (StateW),
    .Depth (NumButtons)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_wr),
    .waddr_i (s1_idx_q[RamAw-1:0]),
    .wdata_i (nxt_st),
    .re_i    (in_acc),
    .raddr_i (s_axis_tuser[RamAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // current state: forwarded update, memory word, or zero for unwritten entry
  always_comb begin
    if (fwd_q) begin
      cur_st = fwd_st_q;
    end else if (rd_vld_q) begin
      cur_st = btn_ctx_t'(ram_rdata);
    end else begin
      cur_st = '0;
    end
  end

  // gesture update for one poll
  always_comb begin
    nxt_st     = cur_st;
    flags      = '0;
    release_ev = 1'b0;
    hold_el    = '0;
    tap_el     = '0;
    hold_long  = 1'b0;
    if (btn_en) begin
      // press edge starts timing
      if (s1_held_q && !cur_st.pressed) begin
        nxt_st.pressed   = 1'b1;
        nxt_st.hold_t0   = s1_now_q;
        nxt_st.long_done = 1'b0;
      end
      hold_el   = s1_now_q - nxt_st.hold_t0;
      hold_long = hold_el >= TimeW'(long_ms_q);
      // release edge: long end or a tap
      if (!s1_held_q && cur_st.pressed) begin
        nxt_st.pressed = 1'b0;
        if (hold_long) begin
          flags.long_end = 1'b1;
        end else begin
          release_ev    = 1'b1;
          nxt_st.tap_t0 = s1_now_q;
          if (cur_st.taps < TapMax) begin
            nxt_st.taps = cur_st.taps + TapW'(1);
          end
        end
      end
      // long start once per hold
      if (nxt_st.pressed && !nxt_st.long_done && hold_long) begin
        nxt_st.long_done = 1'b1;
        flags.long_start = 1'b1;
      end
      // resolve taps after the quiet window
      tap_el = release_ev ? '0 : (s1_now_q - cur_st.tap_t0);
      if ((nxt_st.taps != '0) && !nxt_st.pressed && (tap_el >= TimeW'(dtap_ms_q))) begin
        if (nxt_st.taps >= TapMax) begin
          flags.double_tap = 1'b1;
        end else begin
          flags.single_tap = 1'b1;
        end
        nxt_st.taps = '0;
      end
    end
  end

  // update stage and forwarding control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      ent_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
        fwd_q    <= st_wr & (s1_idx_q == s_axis_tuser);
        rd_vld_q <= ent_vld_q[s_axis_tuser[RamAw-1:0]];
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (st_wr) begin
        ent_vld_q[s1_idx_q[RamAw-1:0]] <= 1'b1;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q  <= s_axis_tuser;
      s1_held_q <= s_axis_tdata[0];
      s1_now_q  <= s_axis_tdata[32:1];
      fwd_st_q  <= nxt_st;
    end
    if (s1_adv) begin
      out_flags_q <= flags;
      out_btn_q   <= s1_idx_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_flags_q};
  assign m_axis_tuser  = out_btn_q;

  // zero fill of the input word is not used
  logic unused_fill;
  assign unused_fill = ^s_axis_tdata[39:33];

  // byte offset and upper write data bits are not used
  logic unused_apb;
  assign unused_apb = ^{paddr[1:0], pwdata[31:ThreshW]};

endmodule
